// ===== src/mwm_pkg.sv =====
// ----------------------------------------------------------------------------
// mwm_pkg
// Types, constants and the quarter-wave sine table shared by the mecanum
// wheel mixer modules.
// ----------------------------------------------------------------------------
package mwm_pkg;

  // Field widths, Q1.15 data.
  localparam int DATA_W    = 16;
  localparam int FRAC_W    = 15;
  localparam int DB_W      = 15;
  localparam int HEADING_W = 16;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 16;
  localparam int LANES     = 4;

  // The sine table depth must be a power of two between 64 and 65536.
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int DEPTH_W   = $clog2(SINE_TABLE_DEPTH);
  localparam int QTR_DEPTH = SINE_TABLE_DEPTH / 4;
  localparam int QTR_W     = DEPTH_W - 2;

  // Internal widths.
  localparam int PROD_W = 2 * DATA_W;            // one rotation product
  localparam int SUM_W  = PROD_W + 1;            // sum of two products
  localparam int ROT_W  = SUM_W - FRAC_W;        // rotated x or y
  localparam int WS_W   = ROT_W + 1;             // raw wheel speed
  localparam int MAG_W  = WS_W - 1;              // wheel speed magnitude
  localparam int NUM_W  = MAG_W + FRAC_W + 1;    // dividend of the normalizer
  localparam int QUO_W  = FRAC_W + 1;            // quotient, at most 1.0

  localparam int FRONT_STAGES = 5;
  localparam int DIV_STAGES   = QUO_W;
  localparam int DIV_DEPTH    = DIV_STAGES + 1;  // operand stage plus one per bit

  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
  localparam logic [FRAC_W-1:0] SINE_MAX = {FRAC_W{1'b1}};
  localparam logic [MAG_W-1:0] ONE_Q15 = MAG_W'(32768);

  localparam logic [DB_W-1:0] DEADBAND_TRANSLATE_RESET = DB_W'(1638);
  localparam logic [DB_W-1:0] DEADBAND_TURN_RESET      = DB_W'(819);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEADBAND_TRANSLATE = 8'd0,
    REG_DEADBAND_TURN      = 8'd1
  } cfg_reg_t;

  typedef struct packed {
    logic                        field_oriented;
    logic        [HEADING_W-1:0] heading;
    logic signed [DATA_W-1:0]    turn;
    logic signed [DATA_W-1:0]    forward;
    logic signed [DATA_W-1:0]    strafe;
  } mwm_cmd_t;

  // Mixed wheel speeds with their magnitudes and the largest magnitude.
  typedef struct packed {
    logic [LANES-1:0][WS_W-1:0]  w;
    logic [LANES-1:0][MAG_W-1:0] mag;
    logic [MAG_W-1:0]            max_mag;
    logic                        scaled;
  } mwm_wheels_t;

  typedef struct packed {
    logic [LANES-1:0][NUM_W-1:0] rem;
    logic [LANES-1:0][QUO_W-1:0] quo;
    logic [MAG_W-1:0]            den;
    logic [LANES-1:0][WS_W-1:0]  w;
    logic                        scaled;
  } mwm_div_stage_t;

  typedef struct packed {
    logic [LANES-1:0][WS_W-1:0]  w;
    logic [LANES-1:0][QUO_W-1:0] quo;
    logic                        scaled;
  } mwm_div_out_t;

  typedef logic [FRAC_W-1:0] sine_qtr_t [QTR_DEPTH];

  // Sine magnitude at quarter-turn position 4*m of the full table, from a
  // degree-13 Taylor series in Q2.30, rounded half up to Q1.15.
  function automatic logic [FRAC_W-1:0] sine_mag(int unsigned m);
    logic [63:0] r;
    logic [63:0] theta;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    r     = 64'(4 * m);
    theta = (PI_HALF_Q30 * r) / SINE_TABLE_DEPTH;
    x2    = (theta * theta) >> 30;
    term  = theta;
    sum   = theta;
    term  = ((term * x2) >> 30) / 6;
    sum   = sum - term;
    term  = ((term * x2) >> 30) / 20;
    sum   = sum + term;
    term  = ((term * x2) >> 30) / 42;
    sum   = sum - term;
    term  = ((term * x2) >> 30) / 72;
    sum   = sum + term;
    term  = ((term * x2) >> 30) / 110;
    sum   = sum - term;
    term  = ((term * x2) >> 30) / 156;
    sum   = sum + term;
    sum   = (sum + 64'd16384) >> 15;
    if (sum > 64'd32767) begin
      sum = 64'd32767;
    end
    return sum[FRAC_W-1:0];
  endfunction

  function automatic sine_qtr_t build_sine_qtr();
    sine_qtr_t t;
    for (int m = 0; m < QTR_DEPTH; m++) begin
      t[m] = sine_mag(m);
    end
    return t;
  endfunction

  localparam sine_qtr_t SINE_QTR = build_sine_qtr();

  // Signed sine of a table index given as quadrant and position in it.
  // An odd quadrant runs backward; the top of a quarter wave is full scale.
  function automatic logic signed [DATA_W-1:0] sine_lookup(logic [1:0] quad,
                                                           logic [QTR_W-1:0] pos);
    logic [QTR_W:0]    mm;
    logic [FRAC_W-1:0] mag;
    mm  = quad[0] ? ((QTR_W+1)'(QTR_DEPTH) - {1'b0, pos}) : {1'b0, pos};
    mag = mm[QTR_W] ? SINE_MAX : SINE_QTR[mm[QTR_W-1:0]];
    return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

endpackage

// ===== src/mwm_rotate_mix.sv =====
// ----------------------------------------------------------------------------
// mwm_rotate_mix
// Deadband, field-oriented rotation and wheel mixing in five pipeline stages,
// ending with the largest wheel speed magnitude.
// ----------------------------------------------------------------------------
module mwm_rotate_mix
  import mwm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [DB_W-1:0]  deadband_translate,
  input  logic [DB_W-1:0]  deadband_turn,
  input  logic             in_valid,
  output logic             in_ready,
  input  mwm_cmd_t         in_cmd,
  output logic             out_valid,
  input  logic             out_ready,
  output mwm_wheels_t      out_wheels
);

  logic [FRONT_STAGES-1:0] v;
  logic [FRONT_STAGES-1:0] en;

  // Stage 1: deadband and sine/cosine lookup.
  logic signed [DATA_W-1:0] s1_x, s1_y, s1_r, s1_sin, s1_cos;
  logic                     s1_fo;
  // Stage 2: rotation products.
  logic signed [PROD_W-1:0] s2_xc, s2_ys, s2_xs, s2_yc;
  logic signed [DATA_W-1:0] s2_x, s2_y, s2_r;
  logic                     s2_fo;
  // Stage 3: rotated translation.
  logic signed [ROT_W-1:0]  s3_x, s3_y;
  logic signed [DATA_W-1:0] s3_r;
  // Stage 4: wheel speeds and magnitudes.
  logic [LANES-1:0][WS_W-1:0]  s4_w;
  logic [LANES-1:0][MAG_W-1:0] s4_mag;
  // Stage 5: largest magnitude.
  mwm_wheels_t s5;

  logic [DEPTH_W-1:0]       idx;
  logic [1:0]               quad;
  logic signed [DATA_W-1:0] x_db, y_db, r_db;
  logic signed [SUM_W-1:0]  sx, sy, sx_rnd, sy_rnd;
  logic signed [ROT_W-1:0]  x_rot, y_rot;
  logic signed [WS_W-1:0]   xe, ye, re;
  logic [LANES-1:0][WS_W-1:0]  w_mix;
  logic [LANES-1:0][MAG_W-1:0] mag_mix;
  logic [MAG_W-1:0]         max01, max23, max_all;

  function automatic logic signed [DATA_W-1:0] deadband(logic signed [DATA_W-1:0] val,
                                                        logic [DB_W-1:0] band);
    logic [DATA_W:0] mag;
    mag = val[DATA_W-1] ? -{val[DATA_W-1], val} : {val[DATA_W-1], val};
    return (mag <= {2'b00, band}) ? '0 : val;
  endfunction

  function automatic logic [MAG_W-1:0] abs_ws(logic signed [WS_W-1:0] val);
    logic [WS_W-1:0] a;
    a = val[WS_W-1] ? -val : val;
    return a[MAG_W-1:0];
  endfunction

  // A stage loads when it is empty or any stage after it can move.
  always_comb begin
    for (int i = 0; i < FRONT_STAGES; i++) begin
      en[i] = out_ready |
              ~&(v | ((FRONT_STAGES'(1) << i) - FRONT_STAGES'(1)));
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[FRONT_STAGES-1];
  assign out_wheels = s5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int i = 1; i < FRONT_STAGES; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // Stage 1 logic. The cosine sits a quarter turn ahead of the sine.
  always_comb begin
    idx  = in_cmd.heading[HEADING_W-1 -: DEPTH_W];
    quad = idx[DEPTH_W-1 -: 2];
    x_db = deadband(in_cmd.strafe,  deadband_translate);
    y_db = deadband(in_cmd.forward, deadband_translate);
    r_db = deadband(in_cmd.turn,    deadband_turn);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_x   <= x_db;
      s1_y   <= y_db;
      s1_r   <= r_db;
      s1_sin <= sine_lookup(quad, idx[QTR_W-1:0]);
      s1_cos <= sine_lookup(quad + 2'd1, idx[QTR_W-1:0]);
      s1_fo  <= in_cmd.field_oriented;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_xc <= s1_x * s1_cos;
      s2_ys <= s1_y * s1_sin;
      s2_xs <= s1_x * s1_sin;
      s2_yc <= s1_y * s1_cos;
      s2_x  <= s1_x;
      s2_y  <= s1_y;
      s2_r  <= s1_r;
      s2_fo <= s1_fo;
    end
  end

  // Stage 3 logic: Q30 sums rounded to Q15, half away from zero, or unrotated x and y.
  always_comb begin
    sx     = {s2_xc[PROD_W-1], s2_xc} - {s2_ys[PROD_W-1], s2_ys};
    sy     = {s2_xs[PROD_W-1], s2_xs} + {s2_yc[PROD_W-1], s2_yc};
    sx_rnd = sx + (sx[SUM_W-1] ? SUM_W'(16383) : SUM_W'(16384));
    sy_rnd = sy + (sy[SUM_W-1] ? SUM_W'(16383) : SUM_W'(16384));
    if (s2_fo) begin
      x_rot = sx_rnd[SUM_W-1:FRAC_W];
      y_rot = sy_rnd[SUM_W-1:FRAC_W];
    end else begin
      x_rot = {{(ROT_W-DATA_W){s2_x[DATA_W-1]}}, s2_x};
      y_rot = {{(ROT_W-DATA_W){s2_y[DATA_W-1]}}, s2_y};
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_x <= x_rot;
      s3_y <= y_rot;
      s3_r <= s2_r;
    end
  end

  // Stage 4 logic: lanes are front left, front right, back left, back right.
  always_comb begin
    xe = {s3_x[ROT_W-1], s3_x};
    ye = {s3_y[ROT_W-1], s3_y};
    re = {{(WS_W-DATA_W){s3_r[DATA_W-1]}}, s3_r};
    w_mix[0] = ye + xe + re;
    w_mix[1] = ye - xe - re;
    w_mix[2] = ye - xe + re;
    w_mix[3] = ye + xe - re;
    for (int l = 0; l < LANES; l++) begin
      mag_mix[l] = abs_ws(w_mix[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_w   <= w_mix;
      s4_mag <= mag_mix;
    end
  end

  always_comb begin
    max01   = (s4_mag[1] > s4_mag[0]) ? s4_mag[1] : s4_mag[0];
    max23   = (s4_mag[3] > s4_mag[2]) ? s4_mag[3] : s4_mag[2];
    max_all = (max23 > max01) ? max23 : max01;
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5.w       <= s4_w;
      s5.mag     <= s4_mag;
      s5.max_mag <= max_all;
      s5.scaled  <= max_all > ONE_Q15;
    end
  end

endmodule

// ===== src/mwm_divider.sv =====
// ----------------------------------------------------------------------------
// mwm_divider
// Pipelined restoring divider that scales four wheel magnitudes by
// 32768 / largest magnitude, rounded, one quotient bit per stage.
// ----------------------------------------------------------------------------
module mwm_divider
  import mwm_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  mwm_wheels_t  in_wheels,
  output logic         out_valid,
  input  logic         out_ready,
  output mwm_div_out_t out_div
);

  logic [DIV_DEPTH-1:0] v;
  logic [DIV_DEPTH-1:0] en;
  mwm_div_stage_t       st  [DIV_DEPTH];
  mwm_div_stage_t       nxt [DIV_DEPTH];

  always_comb begin
    for (int i = 0; i < DIV_DEPTH; i++) begin
      en[i] = out_ready | ~&(v | ((DIV_DEPTH'(1) << i) - DIV_DEPTH'(1)));
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v[DIV_DEPTH-1];
  assign out_div.w      = st[DIV_DEPTH-1].w;
  assign out_div.quo    = st[DIV_DEPTH-1].quo;
  assign out_div.scaled = st[DIV_DEPTH-1].scaled;

  // Operand stage: dividend is mag * 32768 plus half the divisor for rounding.
  // Each later stage settles one quotient bit, most significant first.
  always_comb begin
    logic [NUM_W:0] trial;
    trial = '0;
    nxt[0].den    = in_wheels.max_mag;
    nxt[0].w      = in_wheels.w;
    nxt[0].scaled = in_wheels.scaled;
    nxt[0].quo    = '0;
    for (int l = 0; l < LANES; l++) begin
      nxt[0].rem[l] = (NUM_W'(in_wheels.mag[l]) << FRAC_W) +
                      NUM_W'(in_wheels.max_mag >> 1);
    end
    for (int i = 1; i < DIV_DEPTH; i++) begin
      nxt[i] = st[i-1];
      for (int l = 0; l < LANES; l++) begin
        trial = {1'b0, st[i-1].rem[l]} -
                {1'b0, (NUM_W'(st[i-1].den) << (QUO_W - i))};
        if (!trial[NUM_W]) begin
          nxt[i].rem[l]            = trial[NUM_W-1:0];
          nxt[i].quo[l][QUO_W - i] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int i = 1; i < DIV_DEPTH; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DIV_DEPTH; i++) begin
      if (en[i]) begin
        st[i] <= nxt[i];
      end
    end
  end

endmodule

// ===== src/mecanum_wheel_mixer.sv =====
// ----------------------------------------------------------------------------
// mecanum_wheel_mixer
// Mecanum drive inverse kinematics: deadband, optional field-oriented
// rotation, wheel mixing, normalization and Q1.15 saturation.
// ----------------------------------------------------------------------------
// Pipeline: 5 mixing stages, 17 divider stages and 1 output register from
// the input transfer to m_tvalid.
// Throughput: one command per cycle without back-pressure; the divider's 16
// quotient-bit stages are fully pipelined, so the rate holds when normalizing.
// Reset (rst, synchronous): all pipeline valid bits clear, the deadbands
// return to 0.05 for translation and 0.025 for turn.
// ----------------------------------------------------------------------------
module mecanum_wheel_mixer
  import mwm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // strafe [15:0], forward [31:16], turn [47:32], heading [63:48]
  input  logic [63:0]           s_tdata,
  // field_oriented [0]
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // front_left [15:0], front_right [31:16], back_left [47:32], back_right [63:48]
  output logic [63:0]           m_tdata,
  // was_scaled [0]
  output logic                  m_tuser
);

  logic [DB_W-1:0] deadband_translate;
  logic [DB_W-1:0] deadband_turn;
  mwm_cmd_t        cmd;
  logic            mix_valid, mix_ready;
  mwm_wheels_t     wheels;
  logic            div_valid, div_ready;
  mwm_div_out_t    div_out;
  logic [LANES-1:0][DATA_W-1:0] speed;
  logic            out_en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadband_translate <= DEADBAND_TRANSLATE_RESET;
      deadband_turn      <= DEADBAND_TURN_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DEADBAND_TRANSLATE: deadband_translate <= cfg_data[DB_W-1:0];
        REG_DEADBAND_TURN:      deadband_turn      <= cfg_data[DB_W-1:0];
        default: ;
      endcase
    end
  end

  assign cmd.strafe         = s_tdata[15:0];
  assign cmd.forward        = s_tdata[31:16];
  assign cmd.turn           = s_tdata[47:32];
  assign cmd.heading        = s_tdata[63:48];
  assign cmd.field_oriented = s_tuser;

  mwm_rotate_mix u_rotate_mix (
    .clk                (clk),
    .rst                (rst),
    .deadband_translate (deadband_translate),
    .deadband_turn      (deadband_turn),
    .in_valid           (s_tvalid),
    .in_ready           (s_tready),
    .in_cmd             (cmd),
    .out_valid          (mix_valid),
    .out_ready          (mix_ready),
    .out_wheels         (wheels)
  );

  mwm_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mix_valid),
    .in_ready  (mix_ready),
    .in_wheels (wheels),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_div   (div_out)
  );

  // Scaled lanes take the quotient with the sign of the raw speed; all lanes
  // then saturate, so exactly +1.0 becomes 32767.
  function automatic logic [DATA_W-1:0] lane_out(logic signed [WS_W-1:0] w,
                                                 logic [QUO_W-1:0] quo,
                                                 logic scaled);
    logic signed [WS_W:0] val;
    logic signed [WS_W:0] q_ext;
    q_ext = $signed({{(WS_W+1-QUO_W){1'b0}}, quo});
    if (scaled) begin
      val = w[WS_W-1] ? -q_ext : q_ext;
    end else begin
      val = {w[WS_W-1], w};
    end
    if (val > (WS_W+1)'(32767)) begin
      val = (WS_W+1)'(32767);
    end else if (val < -(WS_W+1)'(32768)) begin
      val = -(WS_W+1)'(32768);
    end
    return val[DATA_W-1:0];
  endfunction

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      speed[l] = lane_out(div_out.w[l], div_out.quo[l], div_out.scaled);
    end
  end

  // Output register: it can reload in the same cycle its transfer completes.
  assign out_en    = !m_tvalid || m_tready;
  assign div_ready = out_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_en) begin
      m_tvalid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      m_tdata <= speed;
      m_tuser <= div_out.scaled;
    end
  end

endmodule

// ===== tb/tb_mecanum_wheel_mixer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mecanum_wheel_mixer
// Self-checking testbench for the mecanum wheel mixer. Drive commands go in
// over the slave stream and wheel speeds are checked on the master stream.
// A behavioral model in this file applies the deadbands, the field-oriented
// rotation, the mix, the normalization and the saturation. The test runs
// directed corner commands, deadband extremes, random traffic under several
// idle and stall mixes, and a long output stall that backs up the pipeline.
// ----------------------------------------------------------------------------
module tb_mecanum_wheel_mixer;
  import mwm_pkg::*;

  localparam int PIPE_LATENCY = 22;
  localparam int SETTLE_CYCLES = PIPE_LATENCY + 10;
  localparam int STALL_LIMIT = 4000;
  localparam int MAX_REPORTS = 10;
  localparam int LONG_HOLD = 600;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'd2;
  localparam logic [HEADING_W-1:0] QUARTER_TURN = 16'd16384;

  typedef struct packed {
    logic                   scaled;
    logic [3:0][DATA_W-1:0] speed;   // front_left in lane 0 up to back_right
  } wheel_result_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [63:0]           s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [63:0]           m_tdata;
  logic                  m_tuser;

  logic [DB_W-1:0] band_translate;
  logic [DB_W-1:0] band_turn;
  int              sine_lut [SINE_TABLE_DEPTH];
  wheel_result_t   pending_wheels [$];
  int              mismatch_count;
  int              src_idle_pct;
  int              sink_stall_pct;
  int              hold_req;
  int              quiet_cycles;

  mecanum_wheel_mixer u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Behavioral model
  // --------------------------------------------------------------------------

  // Sine of table entry k from a degree-13 Taylor series in Q2.30.
  function automatic int taylor_sine(int unsigned k);
    longint unsigned quad, pos, theta, x2, term, acc;
    quad = (4 * k) / SINE_TABLE_DEPTH;
    pos  = 4 * k - quad * SINE_TABLE_DEPTH;
    if (quad[0]) begin
      pos = SINE_TABLE_DEPTH - pos;
    end
    theta = (PI_HALF_Q30 * pos) / SINE_TABLE_DEPTH;
    x2 = (theta * theta) >> 30;
    term = theta;
    acc = theta;
    for (int n = 1; n <= 6; n++) begin
      term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    acc = (acc + 16384) >> 15;
    if (acc > 32767) begin
      acc = 32767;
    end
    return quad[1] ? -int'(acc) : int'(acc);
  endfunction

  function automatic longint sine_at(logic [HEADING_W-1:0] h);
    longint unsigned idx;
    idx = (longint'(h) * SINE_TABLE_DEPTH) >> 16;
    return sine_lut[idx];
  endfunction

  function automatic longint apply_deadband(logic signed [DATA_W-1:0] v,
                                            logic [DB_W-1:0] band);
    longint sv;
    longint mag;
    sv = v;
    mag = (sv < 0) ? -sv : sv;
    return (mag <= longint'(band)) ? 0 : sv;
  endfunction

  // Q30 to Q15, half away from zero.
  function automatic longint round_to_q15(longint v);
    if (v >= 0) begin
      return (v + 16384) >>> 15;
    end
    return -((-v + 16384) >>> 15);
  endfunction

  function automatic logic [DATA_W-1:0] clamp_q15(longint v);
    if (v > 32767) begin
      v = 32767;
    end
    if (v < -32768) begin
      v = -32768;
    end
    return v[DATA_W-1:0];
  endfunction

  function automatic wheel_result_t predict_wheels(mwm_cmd_t c);
    longint x, y, r, sn, cs, xr, yr, peak, mag;
    longint w [4];
    longint unsigned q;
    logic [HEADING_W-1:0] cos_angle;
    wheel_result_t res;
    x = apply_deadband(c.strafe, band_translate);
    y = apply_deadband(c.forward, band_translate);
    r = apply_deadband(c.turn, band_turn);
    cos_angle = c.heading + QUARTER_TURN;
    if (c.field_oriented) begin
      sn = sine_at(c.heading);
      cs = sine_at(cos_angle);
      xr = round_to_q15(x * cs - y * sn);
      yr = round_to_q15(x * sn + y * cs);
      x = xr;
      y = yr;
    end
    w[0] = y + x + r;
    w[1] = y - x - r;
    w[2] = y - x + r;
    w[3] = y + x - r;
    peak = 0;
    for (int i = 0; i < 4; i++) begin
      mag = (w[i] < 0) ? -w[i] : w[i];
      if (mag > peak) begin
        peak = mag;
      end
    end
    res.scaled = (peak > 32768);
    if (res.scaled) begin
      for (int i = 0; i < 4; i++) begin
        mag = (w[i] < 0) ? -w[i] : w[i];
        q = (longint'(mag) * 32768 + peak / 2) / peak;
        w[i] = (w[i] < 0) ? -longint'(q) : longint'(q);
      end
    end
    for (int i = 0; i < 4; i++) begin
      res.speed[i] = clamp_q15(w[i]);
    end
    return res;
  endfunction

  function automatic mwm_cmd_t make_cmd(int sx, int fy, int rt, int h, bit fo);
    mwm_cmd_t c;
    c.strafe = sx[DATA_W-1:0];
    c.forward = fy[DATA_W-1:0];
    c.turn = rt[DATA_W-1:0];
    c.heading = h[HEADING_W-1:0];
    c.field_oriented = fo;
    return c;
  endfunction

  // Random Q1.15 value, weighted toward full scale and the deadband edges.
  function automatic logic [DATA_W-1:0] rand_q15(logic [DB_W-1:0] band);
    int v;
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(5))
          0: v = -32768;
          1: v = 32767;
          2: v = -32767;
          3: v = 1;
          4: v = -1;
          default: v = 0;
        endcase
      end
      1, 2: begin
        v = int'(band) - 1 + $urandom_range(2);
        if (v < 0) begin
          v = 0;
        end
        if (v > 32767) begin
          v = 32767;
        end
        if ($urandom_range(1)) begin
          v = -v;
        end
      end
      default: v = $urandom;
    endcase
    return v[DATA_W-1:0];
  endfunction

  function automatic mwm_cmd_t rand_cmd();
    mwm_cmd_t c;
    c.strafe = rand_q15(band_translate);
    c.forward = rand_q15(band_translate);
    c.turn = rand_q15(band_turn);
    if ($urandom_range(7) == 0) begin
      c.heading = HEADING_W'(QUARTER_TURN * $urandom_range(3) +
                             $urandom_range(128) - 64);
    end else begin
      c.heading = HEADING_W'($urandom);
    end
    c.field_oriented = 1'($urandom_range(1));
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Sends one command and records its expected wheel speeds on the transfer.
  task automatic send_cmd(mwm_cmd_t c);
    wheel_result_t exp_res;
    exp_res = predict_wheels(c);
    if ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      do begin
        @(posedge clk);
      end while ($urandom_range(99) < src_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata <= c[63:0];
    s_tuser <= c.field_oriented;
    do begin
      @(posedge clk);
    end while (!(s_tvalid && s_tready));
    pending_wheels = {pending_wheels, exp_res};
  endtask

  // Lets every expected result come out, then lets the pipeline settle with the input idle.
  task automatic drain_pipeline();
    s_tvalid <= 1'b0;
    while (pending_wheels.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    drain_pipeline();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do begin
      @(posedge clk);
    end while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    case (idx)
      REG_DEADBAND_TRANSLATE: band_translate = value[DB_W-1:0];
      REG_DEADBAND_TURN:      band_turn = value[DB_W-1:0];
      default: ;
    endcase
  endtask

  // Bit 15 of the data lies above the register and is set at random.
  task automatic write_bands(int translate_band, int turn_band);
    write_reg(REG_DEADBAND_TRANSLATE, {1'($urandom_range(1)), DB_W'(translate_band)});
    write_reg(REG_DEADBAND_TURN, {1'($urandom_range(1)), DB_W'(turn_band)});
  endtask

  // --------------------------------------------------------------------------
  // Output side: ready pattern with an optional long hold, and the checker
  // --------------------------------------------------------------------------

  initial begin
    int hold_left;
    hold_left = 0;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  task automatic report_mismatch(string what, longint exp_val, longint got_val);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what,
               exp_val, got_val);
    end
  endtask

  always @(posedge clk) begin
    wheel_result_t exp_res;
    string lane_name [4];
    lane_name = '{"front_left", "front_right", "back_left", "back_right"};
    if (!rst && m_tvalid && m_tready) begin
      if (pending_wheels.size() == 0) begin
        report_mismatch("unexpected result, tdata", 0, longint'(m_tdata));
      end else begin
        exp_res = pending_wheels.pop_front();
        for (int i = 0; i < 4; i++) begin
          if (m_tdata[DATA_W*i +: DATA_W] !== exp_res.speed[i]) begin
            report_mismatch(lane_name[i], longint'($signed(exp_res.speed[i])),
                            longint'($signed(m_tdata[DATA_W*i +: DATA_W])));
          end
        end
        if (m_tuser !== exp_res.scaled) begin
          report_mismatch("was_scaled", longint'(exp_res.scaled), longint'(m_tuser));
        end
      end
    end
  end

  // Ends the run when no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_mecanum_wheel_mixer: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  task automatic test_directed_commands();
    // Deadband edges at the reset bands, then saturation and normalization.
    send_cmd(make_cmd(0, 0, 0, 0, 1'b0));
    send_cmd(make_cmd(1638, -1638, 819, 0, 1'b0));
    send_cmd(make_cmd(1639, -1639, -820, 0, 1'b0));
    send_cmd(make_cmd(-32768, -32768, -32768, 0, 1'b0));
    send_cmd(make_cmd(32767, 32767, 32767, 0, 1'b0));
    send_cmd(make_cmd(16384, 16384, 0, 0, 1'b0));
    send_cmd(make_cmd(-16384, -16384, 0, 0, 1'b0));
    send_cmd(make_cmd(16384, 16384, 1, 0, 1'b0));
    send_cmd(make_cmd(0, 0, 32767, 0, 1'b0));
    send_cmd(make_cmd(5000, 7000, 3000, 12345, 1'b0));
    // Field-oriented rotation at the quadrant points and table boundaries.
    send_cmd(make_cmd(20000, 0, 0, 0, 1'b1));
    send_cmd(make_cmd(20000, 10000, 0, 16384, 1'b1));
    send_cmd(make_cmd(20000, 10000, 2000, 32768, 1'b1));
    send_cmd(make_cmd(-20000, 10000, -2000, 49152, 1'b1));
    send_cmd(make_cmd(-32768, 32767, 0, 65535, 1'b1));
    send_cmd(make_cmd(30000, -30000, 0, 63, 1'b1));
    send_cmd(make_cmd(30000, -30000, 0, 64, 1'b1));
    send_cmd(make_cmd(1000, 32767, 0, 8192, 1'b1));
    send_cmd(make_cmd(-32768, -32768, -32768, 40000, 1'b1));
    send_cmd(make_cmd(32767, 32767, 32767, 24576, 1'b1));
    drain_pipeline();
  endtask

  task automatic test_deadband_extremes();
    write_bands(0, 0);
    repeat (30) send_cmd(rand_cmd());
    send_cmd(make_cmd(1, -1, 1, 0, 1'b0));
    // The widest band zeroes everything except full negative scale.
    write_bands(32767, 32767);
    repeat (30) send_cmd(rand_cmd());
    send_cmd(make_cmd(-32768, 32767, -32768, 0, 1'b1));
    send_cmd(make_cmd(-32767, -32768, 32767, 0, 1'b0));
    write_bands(32767, 0);
    repeat (20) send_cmd(rand_cmd());
    write_bands(0, 32767);
    repeat (20) send_cmd(rand_cmd());
    drain_pipeline();
  endtask

  // A write to an unmapped index must leave both bands as they are.
  task automatic test_unmapped_register();
    write_bands(DEADBAND_TRANSLATE_RESET, DEADBAND_TURN_RESET);
    write_reg(REG_UNMAPPED, 16'h0000);
    write_reg(CFG_IDX_W'($urandom_range(255, 3)), 16'hFFFF);
    send_cmd(make_cmd(1638, 1639, 819, 0, 1'b0));
    send_cmd(make_cmd(-1639, -1638, -820, 0, 1'b0));
    repeat (10) send_cmd(rand_cmd());
    drain_pipeline();
  endtask

  task automatic test_random_traffic(int idle_pct, int stall_pct, int count);
    case ($urandom_range(3))
      0: write_bands(DEADBAND_TRANSLATE_RESET, DEADBAND_TURN_RESET);
      1: write_bands($urandom_range(4095), $urandom_range(4095));
      2: write_bands($urandom_range(32767), $urandom_range(32767));
      default: write_bands(0, $urandom_range(2000));
    endcase
    src_idle_pct = idle_pct;
    sink_stall_pct = stall_pct;
    repeat (count) send_cmd(rand_cmd());
    drain_pipeline();
  endtask

  // The output holds off for a long stretch while commands keep coming, so
  // the pipeline fills and the input has to stall.
  task automatic test_output_backpressure();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    hold_req = LONG_HOLD;
    repeat (120) send_cmd(rand_cmd());
    drain_pipeline();
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    mismatch_count = 0;
    quiet_cycles = 0;
    hold_req = 0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    band_translate = DEADBAND_TRANSLATE_RESET;
    band_turn = DEADBAND_TURN_RESET;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      sine_lut[k] = taylor_sine(k);
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_commands();
    test_deadband_extremes();
    test_unmapped_register();
    test_random_traffic(0, 0, 400);
    test_random_traffic(80, 0, 400);
    test_random_traffic(0, 80, 400);
    test_random_traffic(35, 35, 400);
    test_output_backpressure();

    if (mismatch_count == 0 && pending_wheels.size() == 0) begin
      $display("tb_mecanum_wheel_mixer: clean");
    end else begin
      $display("tb_mecanum_wheel_mixer: errors");
    end
    $finish;
  end

endmodule
